[rtl/core/zlpm_pkg.sv]
// ----------------------------------------------------------------------------
// Zoned log page map package
// Shared types and constants for the zoned log page map with zone cleaning.
// ----------------------------------------------------------------------------
package zlpm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned ZoneW = 8;
  localparam int unsigned SlotW = 16;
  localparam int unsigned AddrW = 64;
  localparam int unsigned CountW = 6;
  localparam int unsigned PartW = 5;
  localparam int unsigned MaxParts = 16;

  localparam logic [PartW-1:0] PartsMax = 5'd16;
  localparam logic [CountW-1:0] LastMoveCount = 6'd63;

  localparam logic [CfgIdxW-1:0] CFG_START_OFFSET = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IO_ZONE_BYTES = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_BYTES = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAGES_PER_ZONE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ZONE_COUNT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PARTS_IN_USE = 3'd5;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef struct packed {
    logic [ZoneW-1:0] zone;
    logic [SlotW-1:0] slot;
  } map_entry_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_NORM   = 10'b0000000010,
    ST_RDCHK  = 10'b0000000100,
    ST_CHK1   = 10'b0000001000,
    ST_CHK2   = 10'b0000010000,
    ST_SCAN   = 10'b0000100000,
    ST_SCANRD = 10'b0001000000,
    ST_MUL    = 10'b0010000000,
    ST_ADD    = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_e;

endpackage

[rtl/core/zoned_log_page_map_gc.sv]
// ----------------------------------------------------------------------------
// Zoned log page map with zone cleaning
// The map entries sit in a small RAM with a valid flag per entry in flops.
// A read lookup passes through the normalise, read-check, multiply, add and
// emit states. A host write checks free space and, while cleaning is due,
// runs cleaning passes that walk the logical pages in use and move each live
// page of the zone being cleaned, using the shared address multiply-add unit
// twice per move. One item is worked on at a time, and each result waits in
// the output register until it is taken.
// ----------------------------------------------------------------------------
module zoned_log_page_map_gc
  import zlpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [3:0]          logical_page_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [3:0]          page_id_o,
  output logic [ZoneW-1:0]    zone_index_o,
  output logic [SlotW-1:0]    slot_index_o,
  output logic [AddrW-1:0]    target_address_o,
  output logic [AddrW-1:0]    source_address_o,
  output logic                unmapped_o,
  output logic                zone_reset_o,
  output logic                zone_finish_o,
  output logic                overflow_o,
  output logic                last_o
);

  localparam int unsigned RamAw = $clog2(MaxParts);

  logic [47:0] start_q;
  logic [36:0] izb_q;
  logic [20:0] pb_q;
  logic [16:0] ppz_q;
  logic [8:0]  zc_q;
  logic [4:0]  parts_q;

  logic [16:0] ppz;
  logic [8:0]  zc;
  logic [PartW-1:0] parts;

  state_e state_q, state_d;
  logic             action_q;
  logic [3:0]       page_q;
  logic [ZoneW-1:0] head_zone_q, clean_zone_q;
  logic [SlotW-1:0] head_slot_q;
  logic [MaxParts-1:0] valid_q;
  logic [PartW-1:0] idx_q;
  logic [8:0]       passes_q;
  logic [CountW-1:0] n_q;
  logic             ovf_q;
  logic [1:0]       kind_q;
  logic             src_phase_q;
  logic             unm_q;
  logic [ZoneW-1:0] mz_q;
  logic [SlotW-1:0] ms_q;
  logic [44:0]      pz_q;
  logic [36:0]      ps_q;
  logic [AddrW-1:0] src_q, tgt_q;
  logic [24:0]      gc_q, hw_q, tot_q;

  logic             ram_we;
  logic [RamAw-1:0] ram_waddr, ram_raddr;
  map_entry_t       ram_wdata, ram_rdata;

  logic [AddrW-1:0] sum;
  logic [24:0]      wp, fr;
  logic             needs;
  logic [PartW-1:0] page_ext;
  logic             page_ok;
  logic             emit_go;
  logic [SlotW-1:0] slot_next;
  logic [ZoneW-1:0] zone_next;
  logic [8:0]       hz_inc;
  logic [ZoneW-1:0] cz_inc;

  assign ppz = (ppz_q < 17'd2) ? 17'd2 : ((ppz_q > 17'd65536) ? 17'd65536 : ppz_q);
  assign zc = (zc_q < 9'd2) ? 9'd2 : ((zc_q > 9'd256) ? 9'd256 : zc_q);
  assign parts = (parts_q == '0) ? PartW'(1) : ((parts_q > PartsMax) ? PartsMax : parts_q);

  assign page_ext = {1'b0, page_q};
  assign page_ok = (page_ext < parts);

  assign sum = AddrW'(start_q) + AddrW'(pz_q) + AddrW'(ps_q);
  assign wp = hw_q + 25'(head_slot_q);
  assign fr = (gc_q <= wp) ? (gc_q + tot_q - wp) : (gc_q - wp);
  assign needs = (fr <= 25'(parts));

  assign emit_go = !out_valid_o || !out_stall_i;

  assign slot_next = head_slot_q + 16'd1;
  assign zone_next = ((9'(head_zone_q) + 9'd1) >= zc) ? '0 : (head_zone_q + 8'd1);
  assign hz_inc = ({1'b0, head_slot_q} >= ppz) ? (9'(head_zone_q) + 9'd1) : 9'(head_zone_q);
  assign cz_inc = ((9'(clean_zone_q) + 9'd1) >= zc) ? '0 : (clean_zone_q + 8'd1);

  assign in_stall_o = (state_q != ST_IDLE);

  zlpm_ram #(
    .Width($bits(map_entry_t)),
    .Depth(MaxParts)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = (kind_q == KIND_MOVE) ? RamAw'(idx_q) : RamAw'(page_ext);
    ram_wdata = '{zone: head_zone_q, slot: head_slot_q};
    ram_raddr = (state_q == ST_NORM) ? RamAw'(page_ext) : RamAw'(idx_q);
    if (state_q == ST_EMIT && emit_go && kind_q != KIND_READ) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      izb_q <= 37'd1073741824;
      pb_q <= 21'd4096;
      ppz_q <= 17'd256;
      zc_q <= 9'd4;
      parts_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_OFFSET:   start_q <= cfg_data_i;
        CFG_IO_ZONE_BYTES:  izb_q <= cfg_data_i[36:0];
        CFG_PAGE_BYTES:     pb_q <= cfg_data_i[20:0];
        CFG_PAGES_PER_ZONE: ppz_q <= cfg_data_i[16:0];
        CFG_ZONE_COUNT:     zc_q <= cfg_data_i[8:0];
        CFG_PARTS_IN_USE:   parts_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_NORM;
      ST_NORM: begin
        if (!action_q) state_d = ST_RDCHK;
        else if (page_ok) state_d = ST_CHK1;
        else state_d = ST_IDLE;
      end
      ST_RDCHK:  state_d = ST_MUL;
      ST_CHK1:   state_d = ST_CHK2;
      ST_CHK2: begin
        if (needs && (passes_q < zc)) state_d = ST_SCAN;
        else state_d = ST_MUL;
      end
      ST_SCAN:   state_d = (idx_q >= parts) ? ST_CHK1 : ST_SCANRD;
      ST_SCANRD: begin
        if (valid_q[idx_q[RamAw-1:0]] && ram_rdata.zone == clean_zone_q) state_d = ST_MUL;
        else state_d = ST_SCAN;
      end
      ST_MUL:    state_d = ST_ADD;
      ST_ADD:    state_d = src_phase_q ? ST_MUL : ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_d = (kind_q == KIND_MOVE) ? ST_SCAN : ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_zone_q <= '0;
      head_slot_q <= '0;
      clean_zone_q <= '0;
      valid_q <= '0;
      out_valid_o <= 1'b0;
      src_phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && emit_go) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        ST_NORM: begin
          if ({1'b0, head_slot_q} >= ppz) head_slot_q <= '0;
          head_zone_q <= (hz_inc >= zc) ? '0 : hz_inc[ZoneW-1:0];
          if (9'(clean_zone_q) >= zc) clean_zone_q <= '0;
        end
        ST_SCAN: begin
          if (idx_q >= parts) clean_zone_q <= cz_inc;
        end
        ST_SCANRD: begin
          if (valid_q[idx_q[RamAw-1:0]] && ram_rdata.zone == clean_zone_q &&
              n_q < LastMoveCount) begin
            src_phase_q <= 1'b1;
          end
        end
        ST_ADD: src_phase_q <= 1'b0;
        ST_EMIT: begin
          if (emit_go) begin
            if (kind_q != KIND_READ) begin
              if (kind_q == KIND_MOVE) valid_q[idx_q[RamAw-1:0]] <= 1'b1;
              else valid_q[page_ext[RamAw-1:0]] <= 1'b1;
              if (17'(slot_next) >= ppz || slot_next == '0) begin
                head_slot_q <= '0;
                head_zone_q <= zone_next;
              end else begin
                head_slot_q <= slot_next;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        action_q <= action_i;
        page_q <= logical_page_i;
        passes_q <= '0;
        n_q <= '0;
        ovf_q <= 1'b0;
      end
      ST_RDCHK: begin
        kind_q <= KIND_READ;
        src_q <= '0;
        unm_q <= !(page_ok && valid_q[page_ext[RamAw-1:0]]);
        mz_q <= ram_rdata.zone;
        ms_q <= ram_rdata.slot;
      end
      ST_CHK1: begin
        gc_q <= 25'(clean_zone_q) * 25'(ppz);
        hw_q <= 25'(head_zone_q) * 25'(ppz);
        tot_q <= 25'(zc) * 25'(ppz);
      end
      ST_CHK2: begin
        kind_q <= KIND_WRITE;
        src_q <= '0;
        unm_q <= 1'b0;
        mz_q <= head_zone_q;
        ms_q <= head_slot_q;
        if (needs) begin
          if (passes_q < zc) begin
            passes_q <= passes_q + 9'd1;
            idx_q <= '0;
          end else begin
            ovf_q <= 1'b1;
          end
        end
      end
      ST_SCANRD: begin
        if (valid_q[idx_q[RamAw-1:0]] && ram_rdata.zone == clean_zone_q) begin
          if (n_q < LastMoveCount) begin
            kind_q <= KIND_MOVE;
            mz_q <= ram_rdata.zone;
            ms_q <= ram_rdata.slot;
          end else begin
            ovf_q <= 1'b1;
            kind_q <= KIND_WRITE;
            src_q <= '0;
            unm_q <= 1'b0;
            mz_q <= head_zone_q;
            ms_q <= head_slot_q;
          end
        end else begin
          idx_q <= idx_q + PartW'(1);
        end
      end
      ST_MUL: begin
        pz_q <= 45'(mz_q) * 45'(izb_q);
        ps_q <= 37'(ms_q) * 37'(pb_q);
      end
      ST_ADD: begin
        if (src_phase_q) begin
          src_q <= sum;
          mz_q <= head_zone_q;
          ms_q <= head_slot_q;
        end else begin
          tgt_q <= sum;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          kind_o <= kind_q;
          page_id_o <= (kind_q == KIND_MOVE) ? idx_q[3:0] : page_q;
          zone_index_o <= unm_q ? '0 : mz_q;
          slot_index_o <= unm_q ? '0 : ms_q;
          target_address_o <= unm_q ? '0 : tgt_q;
          source_address_o <= src_q;
          unmapped_o <= unm_q;
          zone_reset_o <= (kind_q != KIND_READ) && (ms_q == '0);
          zone_finish_o <= (kind_q != KIND_READ) && (17'(ms_q) == ppz - 17'd1);
          overflow_o <= (kind_q == KIND_WRITE) && ovf_q;
          last_o <= (kind_q != KIND_MOVE);
          if (kind_q == KIND_MOVE) begin
            n_q <= n_q + CountW'(1);
            idx_q <= idx_q + PartW'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/zlpm_ram.sv]
// ----------------------------------------------------------------------------
// Zoned log page map RAM
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module zlpm_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(Depth)-1:0]       waddr_i,
  input  logic [Width-1:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0]       raddr_i,
  output logic [Width-1:0]               rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
